[design/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg - shared types and helpers for the look-at view matrix
// Beat payload structs, datapath widths, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // width of the vectors fed to the normaliser (differences and Gram-Schmidt)
  localparam int VEC_W = 36;
  // common width of the product registers, covers every FRAC_BITS in range
  localparam int PW = 68;
  localparam logic [15:0] MIN_LEN_RST = 16'd1;

  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic               bad_input;
    logic               last_row;
  } lav_out_t;

  // x / 2^f, rounding half away from zero
  function automatic prod_t fx_round(input prod_t x, input int f);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = x[PW-1] ? PW'(-x) : PW'(x);
    r = (m + (PW'(1) << (f - 1))) >> f;
    return x[PW-1] ? -prod_t'(r) : prod_t'(r);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input prod_t x);
    logic fits;
    fits = (x[PW-1:31] == '0) || (x[PW-1:31] == '1);
    if (fits) begin
      return x[31:0];
    end
    return x[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

`default_nettype wire

[design/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm - pipelined vector normaliser
// Pre-shift, sum of squares, one root bit per stage, then one quotient bit
// per stage for the three unit components. Side data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [15:0]                 min_length,
  input  logic                        in_vld,
  input  logic signed [VEC_W-1:0]     v [3],
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_vld,
  output logic                        ok,
  output logic signed [FRAC_BITS+1:0] u [3],
  output logic [SIDE_W-1:0]           side_out
);

  localparam int MW   = 31;
  localparam int SQ_N = 32;
  localparam int RW   = 36;
  localparam int QW   = FRAC_BITS + 1;
  localparam int NW   = FRAC_BITS + 33;
  localparam int DRW  = 34;
  localparam int SH_N = VEC_W - MW;
  localparam int SHW  = $clog2(SH_N + 1);

  // pre-shift stage
  logic [VEC_W-1:0] mag [3];
  logic [VEC_W-1:0] mor;
  logic [SHW-1:0]   sh;

  logic              p1_vld;
  logic [MW-1:0]     p1_m [3];
  logic              p1_sgn [3];
  logic              p1_shf;
  logic [SIDE_W-1:0] p1_side;

  logic              p2_vld;
  logic [2*MW-1:0]   p2_sq [3];
  logic [MW-1:0]     p2_m [3];
  logic              p2_sgn [3];
  logic              p2_shf;
  logic [SIDE_W-1:0] p2_side;

  // root stages
  logic              sq_vld  [SQ_N+1];
  logic [63:0]       sq_num  [SQ_N+1];
  logic [RW-1:0]     sq_rem  [SQ_N+1];
  logic [31:0]       sq_root [SQ_N+1];
  logic [MW-1:0]     sq_m    [SQ_N+1][3];
  logic              sq_sgn  [SQ_N+1][3];
  logic              sq_shf  [SQ_N+1];
  logic [SIDE_W-1:0] sq_side [SQ_N+1];
  logic [RW-1:0]     sq_sh   [SQ_N];
  logic [RW-1:0]     sq_t    [SQ_N];
  logic              sq_ge   [SQ_N];

  // divide stages
  logic              dv_vld  [QW+1];
  logic [DRW-1:0]    dv_rem  [QW+1][3];
  logic [QW-1:0]     dv_low  [QW+1][3];
  logic [QW-1:0]     dv_q    [QW+1][3];
  logic [31:0]       dv_len  [QW+1];
  logic              dv_sgn  [QW+1][3];
  logic              dv_bad  [QW+1];
  logic [SIDE_W-1:0] dv_side [QW+1];
  logic [DRW-1:0]    dv_sh   [QW][3];
  logic              dv_ge   [QW][3];
  logic [NW-1:0]     numer   [3];
  logic [31:0]       len;

  // magnitudes and common shift keeping all of them below 2^31
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
    end
    mor = mag[0] | mag[1] | mag[2];
    sh  = '0;
    for (int s = SH_N; s >= 0; s--) begin
      if ((mor >> s) < (VEC_W'(1) << MW)) sh = SHW'(s);
    end
  end

  // root step: bring down two bits, try (root << 2) | 1
  always_comb begin
    for (int k = 0; k < SQ_N; k++) begin
      sq_sh[k] = {sq_rem[k][RW-3:0], sq_num[k][63:62]};
      sq_t[k]  = {2'b00, sq_root[k], 2'b01};
      sq_ge[k] = sq_sh[k] >= sq_t[k];
    end
  end

  // numerator (m << F) + len/2, split into the first partial remainder and the rest
  assign len = sq_root[SQ_N];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = (NW'(sq_m[SQ_N][i]) << FRAC_BITS) + NW'(len >> 1);
    end
  end

  // restoring divide step
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_sh[j][i] = {dv_rem[j][i][DRW-2:0], dv_low[j][i][QW-1]};
        dv_ge[j][i] = dv_sh[j][i] >= DRW'(dv_len[j]);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      out_vld <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) sq_vld[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_vld[j] <= 1'b0;
    end else if (en) begin
      p1_vld    <= in_vld;
      p2_vld    <= p1_vld;
      sq_vld[0] <= p2_vld;
      for (int k = 0; k < SQ_N; k++) sq_vld[k+1] <= sq_vld[k];
      dv_vld[0] <= sq_vld[SQ_N];
      for (int j = 0; j < QW; j++) dv_vld[j+1] <= dv_vld[j];
      out_vld   <= dv_vld[QW];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_m[i]   <= MW'(mag[i] >> sh);
        p1_sgn[i] <= v[i][VEC_W-1];
        p2_sq[i]  <= (2*MW)'(p1_m[i]) * (2*MW)'(p1_m[i]);
        p2_m[i]   <= p1_m[i];
        p2_sgn[i] <= p1_sgn[i];
      end
      p1_shf  <= sh != '0;
      p1_side <= side_in;
      p2_shf  <= p1_shf;
      p2_side <= p1_side;

      sq_num[0]  <= 64'(p2_sq[0]) + 64'(p2_sq[1]) + 64'(p2_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_m[0]    <= p2_m;
      sq_sgn[0]  <= p2_sgn;
      sq_shf[0]  <= p2_shf;
      sq_side[0] <= p2_side;
      for (int k = 0; k < SQ_N; k++) begin
        sq_rem[k+1]  <= sq_ge[k] ? sq_sh[k] - sq_t[k] : sq_sh[k];
        sq_root[k+1] <= {sq_root[k][30:0], sq_ge[k]};
        sq_num[k+1]  <= sq_num[k] << 2;
        sq_m[k+1]    <= sq_m[k];
        sq_sgn[k+1]  <= sq_sgn[k];
        sq_shf[k+1]  <= sq_shf[k];
        sq_side[k+1] <= sq_side[k];
      end

      // degenerate: zero length, or unshifted and under the threshold
      dv_len[0]  <= len;
      dv_bad[0]  <= (len == '0) || (!sq_shf[SQ_N] && (len < 32'(min_length)));
      dv_sgn[0]  <= sq_sgn[SQ_N];
      dv_side[0] <= sq_side[SQ_N];
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= DRW'(numer[i][NW-1:QW]);
        dv_low[0][i] <= numer[i][QW-1:0];
        dv_q[0][i]   <= '0;
      end
      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j+1][i] <= dv_ge[j][i] ? dv_sh[j][i] - DRW'(dv_len[j]) : dv_sh[j][i];
          dv_low[j+1][i] <= dv_low[j][i] << 1;
          dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], dv_ge[j][i]};
        end
        dv_len[j+1]  <= dv_len[j];
        dv_bad[j+1]  <= dv_bad[j];
        dv_sgn[j+1]  <= dv_sgn[j];
        dv_side[j+1] <= dv_side[j];
      end

      // signed unit components
      for (int i = 0; i < 3; i++) begin
        u[i] <= dv_sgn[QW][i] ? -$signed({1'b0, dv_q[QW][i]}) : $signed({1'b0, dv_q[QW][i]});
      end
      ok       <= !dv_bad[QW];
      side_out <= dv_side[QW];
    end
  end

endmodule

`default_nettype wire

[design/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix - left-handed look-at view matrix, signed fixed point
// Output: four row beats per item, one beat per error item; the row serialiser
//   on the output channel sets the pace, and the pipeline takes a beat every
//   cycle while the serialiser has room.
// Reset: synchronous, clears all valid bits and loads min_length with 1.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lav_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lav_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int UW      = FRAC_BITS + 2;
  localparam int RTW     = FRAC_BITS + 3;
  localparam int DPW     = 34;
  localparam int SIDE1_W = 6 * 32;
  localparam int SIDEA_W = 3 * UW;
  localparam int SIDEB_W = 3 * 32;
  localparam logic signed [VEC_W-1:0] ONE_V = VEC_W'(1) << FRAC_BITS;

  logic        adv;
  logic        free;
  logic [15:0] min_length;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LEN_RST;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  // input stage: view difference
  logic                    s0_vld;
  logic signed [31:0]      s0_eye [3];
  logic signed [31:0]      s0_wup [3];
  logic signed [VEC_W-1:0] s0_d [3];

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_eye[0] <= in_data.eye_x;
      s0_eye[1] <= in_data.eye_y;
      s0_eye[2] <= in_data.eye_z;
      s0_wup[0] <= in_data.up_x;
      s0_wup[1] <= in_data.up_y;
      s0_wup[2] <= in_data.up_z;
      s0_d[0]   <= VEC_W'(in_data.target_x) - VEC_W'(in_data.eye_x);
      s0_d[1]   <= VEC_W'(in_data.target_y) - VEC_W'(in_data.eye_y);
      s0_d[2]   <= VEC_W'(in_data.target_z) - VEC_W'(in_data.eye_z);
    end
  end

  // view normaliser
  logic [SIDE1_W-1:0]  n1_side_in;
  logic [SIDE1_W-1:0]  n1_side;
  logic                n1_vld;
  logic                n1_ok;
  logic signed [UW-1:0] n1_u [3];
  logic signed [31:0]  n1_eye [3];
  logic signed [31:0]  n1_wup [3];

  assign n1_side_in = {s0_eye[0], s0_eye[1], s0_eye[2], s0_wup[0], s0_wup[1], s0_wup[2]};

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_norm_view (
    .clk(clk), .rst(rst), .en(adv), .min_length(min_length),
    .in_vld(s0_vld), .v(s0_d), .side_in(n1_side_in),
    .out_vld(n1_vld), .ok(n1_ok), .u(n1_u), .side_out(n1_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_eye[i] = n1_side[SIDE1_W-1-32*i -: 32];
      n1_wup[i] = n1_side[SIDEB_W-1-32*i -: 32];
    end
  end

  // Gram-Schmidt, four stages
  logic                 g1_vld, g2_vld, g3_vld, g4_vld;
  logic                 g1_ok, g2_ok, g3_ok, g4_ok;
  logic signed [UW-1:0] g1_view [3], g2_view [3], g3_view [3], g4_view [3];
  logic signed [31:0]   g1_eye [3], g2_eye [3], g3_eye [3], g4_eye [3];
  logic signed [31:0]   g1_wup [3], g2_wup [3], g3_wup [3];
  prod_t                g1_pw [3], g1_p1 [3], g1_p2 [3];
  logic signed [DPW-1:0] g2_dp;
  logic signed [UW-1:0] g2_r1 [3], g2_r2 [3], g3_r1 [3], g3_r2 [3];
  prod_t                g3_pd [3];
  logic signed [VEC_W-1:0] g4_w0 [3], g4_w1 [3], g4_w2 [3];
  prod_t                dp_sum;
  prod_t                r1_t [3], r2_t [3], pd_t [3];

  always_comb begin
    dp_sum = fx_round(g1_pw[0], FRAC_BITS) + fx_round(g1_pw[1], FRAC_BITS)
           + fx_round(g1_pw[2], FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      r1_t[i] = fx_round(g1_p1[i], FRAC_BITS);
      r2_t[i] = fx_round(g1_p2[i], FRAC_BITS);
      pd_t[i] = fx_round(g3_pd[i], FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
      g2_vld <= 1'b0;
      g3_vld <= 1'b0;
      g4_vld <= 1'b0;
    end else if (adv) begin
      g1_vld <= n1_vld;
      g2_vld <= g1_vld;
      g3_vld <= g2_vld;
      g4_vld <= g3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_ok   <= n1_ok;
      g1_view <= n1_u;
      g1_eye  <= n1_eye;
      g1_wup  <= n1_wup;
      for (int i = 0; i < 3; i++) begin
        g1_pw[i] <= n1_wup[i] * n1_u[i];
        g1_p1[i] <= n1_u[i] * n1_u[1];
        g1_p2[i] <= n1_u[i] * n1_u[2];
      end

      g2_ok   <= g1_ok;
      g2_view <= g1_view;
      g2_eye  <= g1_eye;
      g2_wup  <= g1_wup;
      g2_dp   <= dp_sum[DPW-1:0];
      for (int i = 0; i < 3; i++) begin
        g2_r1[i] <= r1_t[i][UW-1:0];
        g2_r2[i] <= r2_t[i][UW-1:0];
      end

      g3_ok   <= g2_ok;
      g3_view <= g2_view;
      g3_eye  <= g2_eye;
      g3_wup  <= g2_wup;
      g3_r1   <= g2_r1;
      g3_r2   <= g2_r2;
      for (int i = 0; i < 3; i++) begin
        g3_pd[i] <= g2_view[i] * g2_dp;
      end

      // up candidates: world up, then Y axis, then Z axis
      g4_ok   <= g3_ok;
      g4_view <= g3_view;
      g4_eye  <= g3_eye;
      for (int i = 0; i < 3; i++) begin
        g4_w0[i] <= VEC_W'(g3_wup[i]) - pd_t[i][VEC_W-1:0];
        g4_w1[i] <= ((i == 1) ? ONE_V : '0) - VEC_W'(g3_r1[i]);
        g4_w2[i] <= ((i == 2) ? ONE_V : '0) - VEC_W'(g3_r2[i]);
      end
    end
  end

  // three up normalisers side by side
  logic [SIDEA_W-1:0]   na_side_in, na_side;
  logic [SIDEB_W-1:0]   nb_side_in, nb_side;
  logic                 nc_side;
  logic                 na_vld, nb_vld, nc_vld;
  logic                 na_ok, nb_ok, nc_ok;
  logic signed [UW-1:0] na_u [3], nb_u [3], nc_u [3];

  assign na_side_in = {g4_view[0], g4_view[1], g4_view[2]};
  assign nb_side_in = {g4_eye[0], g4_eye[1], g4_eye[2]};

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDEA_W)) u_norm_up (
    .clk(clk), .rst(rst), .en(adv), .min_length(min_length),
    .in_vld(g4_vld), .v(g4_w0), .side_in(na_side_in),
    .out_vld(na_vld), .ok(na_ok), .u(na_u), .side_out(na_side)
  );

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDEB_W)) u_norm_yax (
    .clk(clk), .rst(rst), .en(adv), .min_length(min_length),
    .in_vld(g4_vld), .v(g4_w1), .side_in(nb_side_in),
    .out_vld(nb_vld), .ok(nb_ok), .u(nb_u), .side_out(nb_side)
  );

  lav_norm #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_norm_zax (
    .clk(clk), .rst(rst), .en(adv), .min_length(min_length),
    .in_vld(g4_vld), .v(g4_w2), .side_in(g4_ok),
    .out_vld(nc_vld), .ok(nc_ok), .u(nc_u), .side_out(nc_side)
  );

  // pick up, cross product, translation row
  logic signed [UW-1:0]  sel_up [3], hv [3];
  logic signed [31:0]    he [3];
  logic                  h1_vld, h2_vld, h3_vld;
  logic                  h1_bad, h2_bad, h3_bad;
  logic signed [UW-1:0]  h1_up [3], h2_up [3], h3_up [3];
  logic signed [UW-1:0]  h1_view [3], h2_view [3], h3_view [3];
  logic signed [31:0]    h1_eye [3], h2_eye [3];
  prod_t                 h1_ca [3], h1_cb [3];
  logic signed [RTW-1:0] h2_right [3], h3_right [3];
  prod_t                 h3_pr [3], h3_pu [3], h3_pv [3];
  prod_t                 rt_t [3];
  prod_t                 sum_r, sum_u, sum_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sel_up[i] = na_ok ? na_u[i] : (nb_ok ? nb_u[i] : nc_u[i]);
      hv[i]     = na_side[SIDEA_W-1-UW*i -: UW];
      he[i]     = nb_side[SIDEB_W-1-32*i -: 32];
      rt_t[i]   = fx_round(h1_ca[i] - h1_cb[i], FRAC_BITS);
    end
    sum_r = -(fx_round(h3_pr[0], FRAC_BITS) + fx_round(h3_pr[1], FRAC_BITS)
            + fx_round(h3_pr[2], FRAC_BITS));
    sum_u = -(fx_round(h3_pu[0], FRAC_BITS) + fx_round(h3_pu[1], FRAC_BITS)
            + fx_round(h3_pu[2], FRAC_BITS));
    sum_v = -(fx_round(h3_pv[0], FRAC_BITS) + fx_round(h3_pv[1], FRAC_BITS)
            + fx_round(h3_pv[2], FRAC_BITS));
  end

  // final stage, all four rows
  logic               fin_vld;
  logic               fin_bad;
  logic signed [31:0] fin_col [4][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_vld  <= 1'b0;
      h2_vld  <= 1'b0;
      h3_vld  <= 1'b0;
      fin_vld <= 1'b0;
    end else if (adv) begin
      h1_vld  <= na_vld & nb_vld & nc_vld;
      h2_vld  <= h1_vld;
      h3_vld  <= h2_vld;
      fin_vld <= h3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h1_up   <= sel_up;
      h1_view <= hv;
      h1_eye  <= he;
      h1_bad  <= !nc_side || !(na_ok || nb_ok || nc_ok);
      h1_ca[0] <= sel_up[1] * hv[2];
      h1_cb[0] <= sel_up[2] * hv[1];
      h1_ca[1] <= sel_up[2] * hv[0];
      h1_cb[1] <= sel_up[0] * hv[2];
      h1_ca[2] <= sel_up[0] * hv[1];
      h1_cb[2] <= sel_up[1] * hv[0];

      h2_up   <= h1_up;
      h2_view <= h1_view;
      h2_eye  <= h1_eye;
      h2_bad  <= h1_bad;
      for (int i = 0; i < 3; i++) begin
        h2_right[i] <= rt_t[i][RTW-1:0];
      end

      h3_up    <= h2_up;
      h3_view  <= h2_view;
      h3_right <= h2_right;
      h3_bad   <= h2_bad;
      for (int i = 0; i < 3; i++) begin
        h3_pr[i] <= h2_eye[i] * h2_right[i];
        h3_pu[i] <= h2_eye[i] * h2_up[i];
        h3_pv[i] <= h2_eye[i] * h2_view[i];
      end

      fin_bad <= h3_bad;
      for (int i = 0; i < 3; i++) begin
        fin_col[i][0] <= sat32(prod_t'(h3_right[i]));
        fin_col[i][1] <= sat32(prod_t'(h3_up[i]));
        fin_col[i][2] <= sat32(prod_t'(h3_view[i]));
      end
      fin_col[3][0] <= sat32(sum_r);
      fin_col[3][1] <= sat32(sum_u);
      fin_col[3][2] <= sat32(sum_v);
    end
  end

  // row serialiser: four beats per item, one for an error item
  logic               row_bad;
  logic signed [31:0] row_col [4][3];
  logic [2:0]         cnt;
  logic [1:0]         ridx;

  assign free = (cnt == 3'd0) || ((cnt == 3'd1) && out_ready);
  assign adv  = !fin_vld || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 3'd0;
      ridx <= 2'd0;
    end else if (fin_vld && adv) begin
      cnt  <= fin_bad ? 3'd1 : 3'd4;
      ridx <= 2'd0;
    end else if (out_valid && out_ready) begin
      cnt  <= cnt - 3'd1;
      ridx <= ridx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_vld && adv) begin
      row_col <= fin_col;
      row_bad <= fin_bad;
    end
  end

  assign out_valid = cnt != 3'd0;

  always_comb begin
    out_data.row_index = ridx;
    out_data.col_a     = row_bad ? '0 : row_col[ridx][0];
    out_data.col_b     = row_bad ? '0 : row_col[ridx][1];
    out_data.col_c     = row_bad ? '0 : row_col[ridx][2];
    out_data.bad_input = row_bad;
    out_data.last_row  = row_bad || (ridx == 2'd3);
  end

endmodule

`default_nettype wire
